>>> sv/mfmi_pkg.sv
// Package for the mirrored field map interpolation block.
// Holds the grid sizes, register indexes and the request/result structs.
// Depends on nothing.
`default_nettype none
package mfmi_pkg;
  localparam int GRID_X = 16;
  localparam int GRID_Y = 16;
  localparam int GRID_Z = 256;
  localparam int IX_W = $clog2(GRID_X);
  localparam int IY_W = $clog2(GRID_Y);
  localparam int IZ_W = $clog2(GRID_Z);
  localparam int ADDR_W = 16;
  localparam int FRAC_W = 24;
  localparam int STEP_W = 24;

  typedef enum logic [2:0] {
    REG_POS_X      = 3'd0,
    REG_POS_Y      = 3'd1,
    REG_START_Z    = 3'd2,
    REG_MIN_X      = 3'd3,
    REG_MIN_Y      = 3'd4,
    REG_INV_STEP_X = 3'd5,
    REG_INV_STEP_Y = 3'd6,
    REG_INV_STEP_Z = 3'd7
  } reg_idx_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [15:0]        entry_address;
    logic signed [31:0] load_bx;
    logic signed [31:0] load_by;
    logic signed [31:0] load_bz;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_req_t;

  typedef struct packed {
    logic               inside_res;
    logic signed [31:0] field_bx;
    logic signed [31:0] field_by;
    logic signed [31:0] field_bz;
  } out_res_t;
endpackage
`default_nettype wire

>>> sv/mirrored_field_map_interpolation.sv
// Top level of the mirrored field map interpolation block.
// Holds the field map memory, the query sequencer, one shared multiplier
// for cell location and one shared blend unit. Depends on mfmi_pkg.
//
// A load request writes one map entry (Bx, By, Bz) in the cycle it is taken
// and produces no result; busy stays low, so loads may follow every cycle.
// A query request holds busy high while it runs: it forms the mirrored
// offsets, runs the shared offset-times-reciprocal multiplier (x, y, z),
// checks the cell index, reads the eight cell corners from the single map
// read port (registered read data), runs the shared blend unit (seven blends
// for each of the three components), then applies the mirror signs. A point
// outside the map returns a zero result early, after the offset step or the
// cell index check.
// Each query gives one result on out_res for exactly one cycle with
// out_valid high; the receiver cannot stall it. Entries never loaded read
// as undefined. Write configuration only while busy is low and no result
// is pending.
`default_nettype none
module mirrored_field_map_interpolation
  import mfmi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_req_t     in_req,
  output logic             out_valid,
  output out_res_t         out_res,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_OFFS  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_CHK   = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_BLEND = 7'b0100000,
    ST_SIGN  = 7'b1000000
  } state_t;

  // configuration registers
  logic signed [31:0] pos_x_r, pos_y_r, start_z_r;
  logic [30:0]        min_x_r, min_y_r;
  logic [STEP_W-1:0]  inv_x_r, inv_y_r, inv_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      start_z_r <= '0;
      min_x_r   <= '0;
      min_y_r   <= '0;
      inv_x_r   <= STEP_W'(256);
      inv_y_r   <= STEP_W'(256);
      inv_z_r   <= STEP_W'(256);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_POS_X:      pos_x_r   <= cfg_wdata;
        REG_POS_Y:      pos_y_r   <= cfg_wdata;
        REG_START_Z:    start_z_r <= cfg_wdata;
        REG_MIN_X:      min_x_r   <= cfg_wdata[30:0];
        REG_MIN_Y:      min_y_r   <= cfg_wdata[30:0];
        REG_INV_STEP_X: inv_x_r   <= cfg_wdata[STEP_W-1:0];
        REG_INV_STEP_Y: inv_y_r   <= cfg_wdata[STEP_W-1:0];
        REG_INV_STEP_Z: inv_z_r   <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // map memory: one write port for loads, one registered read port
  logic [95:0]       map_mem [2**ADDR_W];
  logic [95:0]       rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept && in_req.operation == OP_LOAD) begin
      map_mem[in_req.entry_address] <= {in_req.load_bx, in_req.load_by, in_req.load_bz};
    end
    rd_data_r <= map_mem[rd_addr];
  end

  state_t             state_r;
  logic signed [31:0] pt_x_r, pt_y_r, pt_z_r;
  logic [32:0]        u_r [3];
  logic               negx_r, negy_r;
  logic [1:0]         axis_r;
  logic               oor_r;
  logic [IX_W-1:0]    ix_r;
  logic [IY_W-1:0]    iy_r;
  logic [IZ_W-1:0]    iz_r;
  logic [FRAC_W-1:0]  fx_r, fy_r, fz_r;
  logic [3:0]         rd_cnt_r;
  logic [2:0]         lstep_r;
  logic [1:0]         comp_r;
  logic [7:0][2:0][31:0] corner_r;

  assign busy = (state_r != ST_IDLE);

  // offsets and mirroring
  logic signed [32:0] xl, yl, zl;
  logic [32:0]        ax, ay;
  assign xl = {pt_x_r[31], pt_x_r} - {pos_x_r[31], pos_x_r};
  assign yl = {pt_y_r[31], pt_y_r} - {pos_y_r[31], pos_y_r};
  assign zl = {pt_z_r[31], pt_z_r} - {start_z_r[31], start_z_r};
  assign ax = xl[32] ? 33'(-xl) : 33'(xl);
  assign ay = yl[32] ? 33'(-yl) : 33'(yl);

  // shared offset-times-reciprocal multiplier
  logic [32:0]       mul_a;
  logic [STEP_W-1:0] mul_b;
  logic [56:0]       mul_p;
  logic [32:0]       mul_idx;
  always_comb begin
    case (axis_r)
      2'd0:    begin mul_a = u_r[0]; mul_b = inv_x_r; end
      2'd1:    begin mul_a = u_r[1]; mul_b = inv_y_r; end
      default: begin mul_a = u_r[2]; mul_b = inv_z_r; end
    endcase
  end
  assign mul_p   = 57'(mul_a) * 57'(mul_b);
  assign mul_idx = mul_p[56:24];

  // corner address: base cell plus corner offset, wrapped to the map depth
  logic [31:0] base_addr, corner_off;
  assign base_addr  = 32'(ix_r) * 32'(GRID_Y * GRID_Z) + 32'(iy_r) * 32'(GRID_Z)
                    + 32'(iz_r);
  assign corner_off = 32'(rd_cnt_r[2]) * 32'(GRID_Y * GRID_Z)
                    + 32'(rd_cnt_r[1]) * 32'(GRID_Z) + 32'(rd_cnt_r[0]);
  assign rd_addr    = ADDR_W'(base_addr + corner_off);

  // shared blend unit: a + floor((b - a) * f / 2^24)
  logic [2:0]         la, lb;
  logic [FRAC_W-1:0]  lf;
  logic signed [31:0] lv_a, lv_b, lv_res;
  logic signed [32:0] ldiff;
  logic signed [57:0] lprod;
  always_comb begin
    case (lstep_r)
      3'd0, 3'd1, 3'd2, 3'd3: begin la = lstep_r; lb = lstep_r + 3'd4; lf = fx_r; end
      3'd4, 3'd5: begin la = lstep_r - 3'd4; lb = lstep_r - 3'd2; lf = fy_r; end
      default:    begin la = 3'd0; lb = 3'd1; lf = fz_r; end
    endcase
  end
  assign lv_a   = corner_r[la][comp_r];
  assign lv_b   = corner_r[lb][comp_r];
  assign ldiff  = {lv_b[31], lv_b} - {lv_a[31], lv_a};
  assign lprod  = ldiff * $signed({1'b0, lf});
  assign lv_res = 32'(34'(lv_a) + lprod[57:24]);

  // mirror sign, saturating the most negative value
  function automatic logic [31:0] neg_sat(input logic [31:0] v, input logic neg);
    logic [31:0] r;
    if (!neg)                   r = v;
    else if (v == 32'h80000000) r = 32'h7FFFFFFF;
    else                        r = -v;
    return r;
  endfunction

  logic     out_valid_r;
  out_res_t out_res_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= '0;
      rd_cnt_r    <= '0;
      lstep_r     <= '0;
      comp_r      <= '0;
      oor_r       <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept && in_req.operation == OP_QUERY) begin
            pt_x_r  <= in_req.point_x;
            pt_y_r  <= in_req.point_y;
            pt_z_r  <= in_req.point_z;
            state_r <= ST_OFFS;
          end
        end
        ST_OFFS: begin
          negx_r <= xl[32];
          negy_r <= yl[32];
          u_r[0] <= ax - 33'(min_x_r);
          u_r[1] <= ay - 33'(min_y_r);
          u_r[2] <= 33'(zl);
          axis_r <= '0;
          oor_r  <= 1'b0;
          if (ax < 33'(min_x_r) || ay < 33'(min_y_r) || zl[32]) begin
            // drop to a zero result: point lies outside the map
            out_res_r   <= '0;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          case (axis_r)
            2'd0: begin
              ix_r <= mul_idx[IX_W-1:0];
              fx_r <= mul_p[FRAC_W-1:0];
              if (mul_idx >= 33'(GRID_X - 1)) oor_r <= 1'b1;
            end
            2'd1: begin
              iy_r <= mul_idx[IY_W-1:0];
              fy_r <= mul_p[FRAC_W-1:0];
              if (mul_idx >= 33'(GRID_Y - 1)) oor_r <= 1'b1;
            end
            default: begin
              iz_r <= mul_idx[IZ_W-1:0];
              fz_r <= mul_p[FRAC_W-1:0];
              if (mul_idx >= 33'(GRID_Z - 1)) oor_r <= 1'b1;
            end
          endcase
          if (axis_r == 2'd2) state_r <= ST_CHK;
          else axis_r <= axis_r + 2'd1;
        end
        ST_CHK: begin
          rd_cnt_r <= '0;
          if (oor_r) begin
            out_res_r   <= '0;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          // read data is registered and arrives in the cycle after its address
          if (rd_cnt_r != 4'd0) corner_r[3'(rd_cnt_r - 4'd1)] <= rd_data_r;
          if (rd_cnt_r == 4'd8) begin
            // blend Bx first, then By, then Bz
            lstep_r <= '0;
            comp_r  <= 2'd2;
            state_r <= ST_BLEND;
          end else begin
            rd_cnt_r <= rd_cnt_r + 4'd1;
          end
        end
        ST_BLEND: begin
          corner_r[la][comp_r] <= lv_res;
          if (lstep_r == 3'd6) begin
            lstep_r <= '0;
            if (comp_r == 2'd0) state_r <= ST_SIGN;
            else comp_r <= comp_r - 2'd1;
          end else begin
            lstep_r <= lstep_r + 3'd1;
          end
        end
        ST_SIGN: begin
          out_res_r.inside_res <= 1'b1;
          out_res_r.field_bx   <= neg_sat(corner_r[0][2], negx_r ^ negy_r);
          out_res_r.field_by   <= corner_r[0][1];
          out_res_r.field_bz   <= neg_sat(corner_r[0][0], negy_r);
          out_valid_r          <= 1'b1;
          state_r              <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // a result leaves only as a query ends, so busy has dropped with it
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  // an accepted query occupies the sequencer next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.operation == OP_QUERY) |=> busy)
    else $error("query not started");
  // points outside the map return all-zero fields
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.inside_res) |->
      (out_res.field_bx == 0 && out_res.field_by == 0 && out_res.field_bz == 0))
    else $error("nonzero field outside map");

endmodule
`default_nettype wire

>>> test/mfmi_checker.sv
// Checker for the mirrored field map interpolation block: watches requests,
// register writes and results, predicts each query and compares field by field.
// Depends on mfmi_pkg.
module mfmi_checker
  import mfmi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  out_res_t out_res,
  input  logic     cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_wdata,
  output int       fail_count,
  output int       pending
);
  longint origin_x, origin_y, origin_z;
  longint floor_x, floor_y;
  longint recip_x, recip_y, recip_z;

  logic signed [31:0] map_bx [65536];
  logic signed [31:0] map_by [65536];
  logic signed [31:0] map_bz [65536];

  out_res_t field_q[$];

  initial begin
    fail_count = 0;
    pending = 0;
    for (int i = 0; i < 65536; i++) begin
      map_bx[i] = '0;
      map_by[i] = '0;
      map_bz[i] = '0;
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic longint lerp(longint a, longint b, longint f);
    longint d;
    d = (b - a) * f;
    return a + (d >>> FRAC_W);
  endfunction

  function automatic longint corner(int comp, longint addr);
    int unsigned k;
    k = int'(addr) & 32'hFFFF;
    case (comp)
      0: return longint'(map_bx[k]);
      1: return longint'(map_by[k]);
      default: return longint'(map_bz[k]);
    endcase
  endfunction

  // Blend x first, then y, then z.
  function automatic longint trilerp(int comp, longint ix, longint iy, longint iz,
                                     longint fx, longint fy, longint fz);
    longint c[2][2][2];
    longint e[2][2];
    longint g[2];
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        for (int d = 0; d < 2; d++)
          c[a][b][d] = corner(comp, (ix + a) * GRID_Y * GRID_Z + (iy + b) * GRID_Z + iz + d);
    for (int b = 0; b < 2; b++)
      for (int d = 0; d < 2; d++)
        e[b][d] = lerp(c[0][b][d], c[1][b][d], fx);
    for (int d = 0; d < 2; d++)
      g[d] = lerp(e[0][d], e[1][d], fy);
    return lerp(g[0], g[1], fz);
  endfunction

  function automatic longint negate_sat(longint v, bit flip);
    if (!flip) return v;
    return (-v > 64'sd2147483647) ? 64'sd2147483647 : -v;
  endfunction

  function automatic out_res_t field_at(in_req_t r);
    out_res_t res;
    longint xl, yl, zl, sx, sy, sz, ix, iy, iz, bx, by, bz;
    bit negx, negy;
    res = '0;
    xl = longint'(r.point_x) - origin_x;
    yl = longint'(r.point_y) - origin_y;
    zl = longint'(r.point_z) - origin_z;
    negx = xl < 0;
    negy = yl < 0;
    if (negx) xl = -xl;
    if (negy) yl = -yl;
    if (xl < floor_x || yl < floor_y || zl < 0) return res;
    sx = (xl - floor_x) * recip_x;
    sy = (yl - floor_y) * recip_y;
    sz = zl * recip_z;
    ix = sx >> FRAC_W;
    iy = sy >> FRAC_W;
    iz = sz >> FRAC_W;
    if (ix >= GRID_X - 1 || iy >= GRID_Y - 1 || iz >= GRID_Z - 1) return res;
    sx = sx & 64'hFFFFFF;
    sy = sy & 64'hFFFFFF;
    sz = sz & 64'hFFFFFF;
    bx = trilerp(0, ix, iy, iz, sx, sy, sz);
    by = trilerp(1, ix, iy, iz, sx, sy, sz);
    bz = trilerp(2, ix, iy, iz, sx, sy, sz);
    res.inside_res = 1'b1;
    res.field_bx = 32'(negate_sat(bx, negx ^ negy));
    res.field_by = 32'(by);
    res.field_bz = 32'(negate_sat(bz, negy));
    return res;
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    if (!rst_n) begin
      origin_x = 0; origin_y = 0; origin_z = 0;
      floor_x = 0; floor_y = 0;
      recip_x = 256; recip_y = 256; recip_z = 256;
    end else begin
      if (out_valid) begin
        if (field_q.size() == 0) begin
          report("unexpected result", out_res.field_bx, '0);
        end else begin
          want = field_q.pop_front();
          if (out_res.inside_res !== want.inside_res)
            report("inside", 32'(out_res.inside_res), 32'(want.inside_res));
          if (out_res.field_bx !== want.field_bx) report("bx", out_res.field_bx, want.field_bx);
          if (out_res.field_by !== want.field_by) report("by", out_res.field_by, want.field_by);
          if (out_res.field_bz !== want.field_bz) report("bz", out_res.field_bz, want.field_bz);
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_POS_X:      origin_x = longint'($signed(cfg_wdata));
          REG_POS_Y:      origin_y = longint'($signed(cfg_wdata));
          REG_START_Z:    origin_z = longint'($signed(cfg_wdata));
          REG_MIN_X:      floor_x = longint'(cfg_wdata[30:0]);
          REG_MIN_Y:      floor_y = longint'(cfg_wdata[30:0]);
          REG_INV_STEP_X: recip_x = longint'(cfg_wdata[23:0]);
          REG_INV_STEP_Y: recip_y = longint'(cfg_wdata[23:0]);
          REG_INV_STEP_Z: recip_z = longint'(cfg_wdata[23:0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_req.operation == OP_LOAD) begin
          map_bx[in_req.entry_address] = in_req.load_bx;
          map_by[in_req.entry_address] = in_req.load_by;
          map_bz[in_req.entry_address] = in_req.load_bz;
        end else begin
          field_q.push_back(field_at(in_req));
        end
      end
    end
    pending = field_q.size();
  end
endmodule

>>> test/tb_mirrored_field_map_interpolation.sv
// Testbench top for the mirrored field map interpolation block: loads the map
// cells that queries touch, runs directed and random load/query requests under
// several register settings. Depends on mfmi_pkg, mfmi_checker and the block.
module tb_mirrored_field_map_interpolation;
  import mfmi_pkg::*;

  localparam int SETTLE = 60;      // longer than the slowest query
  localparam int WATCHDOG = 4000;
  localparam int AIM_XY = 2;       // cells spanned by aimed x and y
  localparam int AIM_Z = 4;        // cells spanned by aimed z

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_req_t     in_req;
  logic        out_valid;
  out_res_t    out_res;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          stall_pct;
  int          quiet_cycles;

  // Current register values, kept here to aim query points into the grid.
  logic [31:0] regs [8];
  // Map entries loaded so far; queries only touch these.
  bit          written [65536];

  mirrored_field_map_interpolation i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mfmi_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // End the run when nothing at all moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request, maybe after a random gap, and hold it until taken.
  task automatic send(in_req_t r);
    if (r.operation == OP_LOAD) written[r.entry_address] = 1'b1;
    if ($urandom_range(99) < stall_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every expected result is back, then let the
  // block settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all eight registers, one per cycle, holding the enable between them.
  task automatic write_regs(logic [31:0] v [8]);
    reg_idx_t ri;
    ri = ri.first();
    for (int n = 0; n < 8; n++) begin
      cfg_we <= 1'b1;
      cfg_index <= ri;
      cfg_wdata <= v[ri];
      regs[ri] = v[ri];
      @(posedge clk);
      ri = ri.next();
    end
    cfg_we <= 1'b0;
  endtask

  function automatic in_req_t load_req(logic [15:0] a, logic [31:0] bx, logic [31:0] by,
                                       logic [31:0] bz);
    in_req_t r;
    r = in_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.operation = OP_LOAD;
    r.entry_address = a;
    r.load_bx = bx;
    r.load_by = by;
    r.load_bz = bz;
    return r;
  endfunction

  function automatic in_req_t query_req(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    in_req_t r;
    r = in_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.operation = OP_QUERY;
    r.point_x = px;
    r.point_y = py;
    r.point_z = pz;
    return r;
  endfunction

  // Find the first corner address of the cell a query reads under the
  // current registers; return 0 when the point lies outside the map.
  function automatic bit query_cell(in_req_t r, output longint base);
    longint xl, yl, zl, ix, iy, iz;
    base = 0;
    xl = longint'(r.point_x) - longint'($signed(regs[REG_POS_X]));
    yl = longint'(r.point_y) - longint'($signed(regs[REG_POS_Y]));
    zl = longint'(r.point_z) - longint'($signed(regs[REG_START_Z]));
    if (xl < 0) xl = -xl;
    if (yl < 0) yl = -yl;
    if (xl < longint'(regs[REG_MIN_X][30:0]) || yl < longint'(regs[REG_MIN_Y][30:0]) ||
        zl < 0)
      return 1'b0;
    ix = ((xl - longint'(regs[REG_MIN_X][30:0])) *
          longint'(regs[REG_INV_STEP_X][23:0])) >> FRAC_W;
    iy = ((yl - longint'(regs[REG_MIN_Y][30:0])) *
          longint'(regs[REG_INV_STEP_Y][23:0])) >> FRAC_W;
    iz = (zl * longint'(regs[REG_INV_STEP_Z][23:0])) >> FRAC_W;
    if (ix >= GRID_X - 1 || iy >= GRID_Y - 1 || iz >= GRID_Z - 1) return 1'b0;
    base = ix * GRID_Y * GRID_Z + iy * GRID_Z + iz;
    return 1'b1;
  endfunction

  // Load any corner a query would read that has never been loaded, then
  // send the request itself.
  task automatic issue(in_req_t r);
    longint      base;
    bit          hit;
    int unsigned addr;
    hit = query_cell(r, base);
    if (r.operation == OP_QUERY && hit) begin
      for (int a = 0; a < 2; a++)
        for (int b = 0; b < 2; b++)
          for (int d = 0; d < 2; d++) begin
            addr = 32'(base + a * GRID_Y * GRID_Z + b * GRID_Z + d) & 32'hFFFF;
            if (!written[addr]) send(load_req(16'(addr), $urandom, $urandom, $urandom));
          end
    end
    send(r);
  endtask

  // Pick a coordinate whose cell index lands in the first few cells, with a
  // small margin past them; mirror it to the negative side at random.
  function automatic logic [31:0] aim(logic [31:0] origin, longint base, longint recip,
                                      int cells, bit mirror);
    longint span, u;
    if (recip == 0) span = 64'hFFFF;
    else span = (longint'(cells) << FRAC_W) / recip + 2;
    if (span > 64'hFFFFFFFF) span = 64'hFFFFFFFF;
    u = base + longint'($urandom_range(0, 32'(span)));
    if (mirror && $urandom_range(1)) u = -u;
    return 32'(longint'($signed(origin)) + u);
  endfunction

  function automatic in_req_t aimed_query();
    return query_req(
      aim(regs[REG_POS_X], longint'(regs[REG_MIN_X][30:0]), longint'(regs[REG_INV_STEP_X]),
          AIM_XY, 1'b1),
      aim(regs[REG_POS_Y], longint'(regs[REG_MIN_Y][30:0]), longint'(regs[REG_INV_STEP_Y]),
          AIM_XY, 1'b1),
      aim(regs[REG_START_Z], 0, longint'(regs[REG_INV_STEP_Z]), AIM_Z, 1'b0));
  endfunction

  // Mostly aimed queries, some reloads of map entries, some raw noise.
  task automatic random_run(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 20) issue(load_req(16'($urandom), $urandom, $urandom, $urandom));
      else if (pick < 85) issue(aimed_query());
      else issue(query_req($urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    logic [31:0] v [8];
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    quiet_cycles = 0;
    stall_pct = 27;
    regs[REG_POS_X] = 0; regs[REG_POS_Y] = 0; regs[REG_START_Z] = 0;
    regs[REG_MIN_X] = 0; regs[REG_MIN_Y] = 0;
    regs[REG_INV_STEP_X] = 256; regs[REG_INV_STEP_Y] = 256; regs[REG_INV_STEP_Z] = 256;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset settings.
    // Most negative value in every corner of cell 0: negation must saturate.
    foreach (v[k]) v[k] = 0;
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        for (int d = 0; d < 2; d++)
          send(load_req(16'(a * 4096 + b * 256 + d), 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000));
    issue(query_req(32'hFFFF_FFFF, 32'd1, 32'd0));          // x mirrored only
    issue(query_req(32'd1, 32'hFFFF_FFFF, 32'd0));          // y mirrored only
    issue(query_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));  // both mirrored
    issue(query_req(32'd0, 32'd0, 32'd0));                  // grid origin exactly
    send(load_req(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    send(load_req(16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    issue(query_req(32'd0, 32'd0, 32'd0));
    issue(query_req(32'h000E_FFFF, 32'h000E_FFFF, 32'h00FE_FFFF)); // last cell, top
    issue(query_req(32'h000F_0000, 32'd5, 32'd5));          // x index one past
    issue(query_req(32'd5, 32'h000F_0000, 32'd5));          // y index one past
    issue(query_req(32'd5, 32'd5, 32'h00FF_0000));          // z index one past
    issue(query_req(32'd5, 32'd5, 32'hFFFF_FFFF));          // z below start
    issue(query_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    issue(query_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    issue(query_req(32'h0001_2345, 32'hFFFE_DCBA, 32'h0042_1111));
    random_run(300);

    // Hold off until the block has nothing in flight before changing settings.
    drain();
    v[REG_POS_X] = 32'h0000_1000; v[REG_POS_Y] = 32'hFFFF_F000; v[REG_START_Z] = 32'h0000_0800;
    v[REG_MIN_X] = 32'h0000_0100; v[REG_MIN_Y] = 32'h0000_0040;
    v[REG_INV_STEP_X] = 32'h0010_0000; v[REG_INV_STEP_Y] = 32'h0008_0000;
    v[REG_INV_STEP_Z] = 32'h0100_0000 >> 2;
    write_regs(v);
    issue(query_req(32'h0000_0F00, 32'hFFFF_EF00, 32'h0000_0800)); // exactly at min_x, mirrored
    random_run(350);

    // Extremes: origin at the far ends, largest minimum and reciprocal.
    drain();
    v[REG_POS_X] = 32'h8000_0000; v[REG_POS_Y] = 32'h7FFF_FFFF; v[REG_START_Z] = 32'h8000_0000;
    v[REG_MIN_X] = 32'h7FFF_FFFF; v[REG_MIN_Y] = 32'h7FFF_FFFF;
    v[REG_INV_STEP_X] = 32'h00FF_FFFF; v[REG_INV_STEP_Y] = 32'h00FF_FFFF;
    v[REG_INV_STEP_Z] = 32'h00FF_FFFF;
    write_regs(v);
    random_run(350);

    // Zero reciprocals: every axis collapses to index 0, fraction 0.
    drain();
    stall_pct = 71;
    foreach (v[k]) v[k] = $urandom_range(0, 32'h0000_FFFF);
    v[REG_INV_STEP_X] = 0; v[REG_INV_STEP_Y] = 0; v[REG_INV_STEP_Z] = 0;
    write_regs(v);
    random_run(350);

    // Random settings with steps in a useful range.
    drain();
    stall_pct = 0;
    v[REG_POS_X] = $urandom; v[REG_POS_Y] = $urandom; v[REG_START_Z] = $urandom;
    v[REG_MIN_X] = $urandom_range(0, 32'h0010_0000);
    v[REG_MIN_Y] = $urandom_range(0, 32'h0010_0000);
    v[REG_INV_STEP_X] = $urandom_range(1, 32'h0040_0000);
    v[REG_INV_STEP_Y] = $urandom_range(1, 32'h0040_0000);
    v[REG_INV_STEP_Z] = $urandom_range(1, 32'h0040_0000);
    write_regs(v);
    random_run(350);

    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
